@@ rtl/core/vrle_pkg.sv @@
// Shared types, constants and helpers of the voxel run-length encoder.
package vrle_pkg;

  localparam int MAX_SIDE_POWER = 10;
  localparam int POWER_W        = 4;
  localparam int VOXEL_W        = 8;
  localparam int COUNT_W        = 31;
  localparam int SEEN_W         = 31;
  localparam int SUM_W          = 5;
  localparam int REG_INDEX_W    = 2;

  localparam logic [REG_INDEX_W-1:0] REG_WIDTH_POWER  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_HEIGHT_POWER = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_DEPTH_POWER  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCOUNT_W    = 2;

  typedef struct packed {
    logic                has_hdr;
    logic                has_mid;
    logic                has_end;
    logic [POWER_W-1:0]  wp;
    logic [POWER_W-1:0]  hp;
    logic [POWER_W-1:0]  dp;
    logic [VOXEL_W-1:0]  mid_value;
    logic [COUNT_W-1:0]  mid_count;
    logic [VOXEL_W-1:0]  end_value;
    logic [COUNT_W-1:0]  end_count;
  } cmd_t;

  function automatic logic [POWER_W-1:0] clamp_power(input logic [POWER_W-1:0] p);
    if (p > POWER_W'(MAX_SIDE_POWER)) begin
      return POWER_W'(MAX_SIDE_POWER);
    end
    return p;
  endfunction

endpackage

@@ rtl/core/vrle_front.sv @@
// Front end: accepts voxels, tracks the current run and emits output requests.
module vrle_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vrle_pkg::VOXEL_W-1:0] voxel,
  input  logic [vrle_pkg::POWER_W-1:0] wp,
  input  logic [vrle_pkg::POWER_W-1:0] hp,
  input  logic [vrle_pkg::POWER_W-1:0] dp,
  output logic                       push_valid,
  input  logic                       push_ready,
  output vrle_pkg::cmd_t             push_cmd
);
  import vrle_pkg::*;

  logic               first_pending;
  logic [VOXEL_W-1:0] run_value;
  logic [COUNT_W-1:0] run_count;
  logic [SEEN_W-1:0]  voxels_seen;

  logic               accept;
  logic [SUM_W-1:0]   size_sum;
  logic [SEEN_W-1:0]  total;
  logic [SEEN_W-1:0]  seen_next;
  logic [VOXEL_W-1:0] value_next;
  logic [COUNT_W-1:0] count_next;
  logic               emit_mid;
  logic               vol_end;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign size_sum = SUM_W'(wp) + SUM_W'(hp) + SUM_W'(dp);
  assign total    = SEEN_W'(1) << size_sum;

  always_comb begin
    emit_mid   = 1'b0;
    value_next = voxel;
    count_next = COUNT_W'(1);
    if (first_pending) begin
      seen_next = SEEN_W'(1);
    end else begin
      seen_next = voxels_seen + SEEN_W'(1);
      if (voxel == run_value) begin
        value_next = run_value;
        count_next = run_count + COUNT_W'(1);
      end else begin
        emit_mid = 1'b1;
      end
    end
    vol_end = (seen_next >= total);
  end

  always_comb begin
    push_cmd.has_hdr   = first_pending;
    push_cmd.has_mid   = emit_mid;
    push_cmd.has_end   = vol_end;
    push_cmd.wp        = wp;
    push_cmd.hp        = hp;
    push_cmd.dp        = dp;
    push_cmd.mid_value = run_value;
    push_cmd.mid_count = run_count;
    push_cmd.end_value = value_next;
    push_cmd.end_count = count_next;
  end

  assign push_valid = accept && (first_pending || emit_mid || vol_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      run_value     <= '0;
      run_count     <= '0;
      voxels_seen   <= '0;
    end else if (accept) begin
      if (vol_end) begin
        first_pending <= 1'b1;
        run_value     <= '0;
        run_count     <= '0;
        voxels_seen   <= '0;
      end else begin
        first_pending <= 1'b0;
        run_value     <= value_next;
        run_count     <= count_next;
        voxels_seen   <= seen_next;
      end
    end
  end

endmodule

@@ rtl/core/vrle_queue.sv @@
// Two-entry request queue between the front end and the byte serializer.
module vrle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vrle_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vrle_pkg::cmd_t pop_cmd
);
  import vrle_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != QCOUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCOUNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/vrle_back.sv @@
// Back end: turns one queued request into its header, value and count bytes.
module vrle_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  vrle_pkg::cmd_t               pop_cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vrle_pkg::VOXEL_W-1:0] out_byte,
  output logic                         last_of_item,
  output logic                         end_of_stream
);
  import vrle_pkg::*;

  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_WP     = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_HP     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_DP     = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_MID_V  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_MID_C0 = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_MID_C1 = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_MID_C2 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_MID_C3 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_END_V  = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_END_C0 = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_END_C1 = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_END_C2 = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_END_C3 = 4'd12;

  cmd_t              cmd;
  logic              busy;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] last_slot;
  logic              at_last;
  logic              take;

  always_comb begin
    if (pop_cmd.has_hdr) begin
      start_slot = SLOT_WP;
    end else if (pop_cmd.has_mid) begin
      start_slot = SLOT_MID_V;
    end else begin
      start_slot = SLOT_END_V;
    end
    if (cmd.has_end) begin
      last_slot = SLOT_END_C3;
    end else if (cmd.has_mid) begin
      last_slot = SLOT_MID_C3;
    end else begin
      last_slot = SLOT_DP;
    end
  end

  // After a header, the final pair follows directly when no run closed and the volume ends.
  always_comb begin
    if (slot == SLOT_DP) begin
      slot_next = cmd.has_mid ? SLOT_MID_V : SLOT_END_V;
    end else begin
      slot_next = slot + SLOT_W'(1);
    end
  end

  assign at_last   = (slot == last_slot);
  assign out_valid = busy;
  assign take      = out_valid && out_ready;
  assign pop_ready = !busy || (take && at_last);

  assign last_of_item  = at_last;
  assign end_of_stream = at_last && cmd.has_end;

  always_comb begin
    case (slot)
      SLOT_WP:     out_byte = VOXEL_W'(cmd.wp);
      SLOT_HP:     out_byte = VOXEL_W'(cmd.hp);
      SLOT_DP:     out_byte = VOXEL_W'(cmd.dp);
      SLOT_MID_V:  out_byte = cmd.mid_value;
      SLOT_MID_C0: out_byte = cmd.mid_count[7:0];
      SLOT_MID_C1: out_byte = cmd.mid_count[15:8];
      SLOT_MID_C2: out_byte = cmd.mid_count[23:16];
      SLOT_MID_C3: out_byte = {1'b0, cmd.mid_count[30:24]};
      SLOT_END_V:  out_byte = cmd.end_value;
      SLOT_END_C0: out_byte = cmd.end_count[7:0];
      SLOT_END_C1: out_byte = cmd.end_count[15:8];
      SLOT_END_C2: out_byte = cmd.end_count[23:16];
      SLOT_END_C3: out_byte = {1'b0, cmd.end_count[30:24]};
      default:     out_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cmd <= pop_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (pop_valid && pop_ready) begin
      busy <= 1'b1;
      slot <= start_slot;
    end else if (take) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        slot <= slot_next;
      end
    end
  end

endmodule

@@ rtl/core/voxel_run_length_encoder_top.sv @@
// Top level of the voxel run-length encoder: size registers, front end, queue and serializer.
//
// Voxels are taken one per cycle while the two-entry request queue has room.
// A voxel that extends the current run produces no bytes; the first voxel of
// a volume produces three header bytes, a voxel that ends a run produces five
// bytes (value, then a four-byte count of 31 bits, least significant byte
// first), and the last voxel of a volume adds its final five-byte pair. The
// byte serializer sends one byte per cycle while out_ready is high, so it sets
// the sustained rate: five bytes per voxel when every voxel differs, eight for
// a one-voxel volume and ten for a volume's last voxel that also closes a run.
// Size powers above 10 are treated as 10. The size registers
// are written through cfg_we/cfg_index/cfg_data and must be stable while a
// volume is being encoded for the header to match the volume length.
module voxel_run_length_encoder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vrle_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [vrle_pkg::POWER_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [vrle_pkg::VOXEL_W-1:0]     voxel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [vrle_pkg::VOXEL_W-1:0]     out_byte,
  output logic                             last_of_item,
  output logic                             end_of_stream
);
  import vrle_pkg::*;

  logic [POWER_W-1:0] width_power;
  logic [POWER_W-1:0] height_power;
  logic [POWER_W-1:0] depth_power;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_power  <= '0;
      height_power <= '0;
      depth_power  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_POWER:  width_power  <= cfg_data;
        REG_HEIGHT_POWER: height_power <= cfg_data;
        REG_DEPTH_POWER:  depth_power  <= cfg_data;
        default: ;
      endcase
    end
  end

  vrle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .voxel      (voxel),
    .wp         (clamp_power(width_power)),
    .hp         (clamp_power(height_power)),
    .dp         (clamp_power(depth_power)),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  vrle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  vrle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_item  (last_of_item),
    .end_of_stream (end_of_stream)
  );

endmodule
